### hdl/w2s_pkg.sv
// Shared types and constants for the world-to-screen projection unit.
package w2s_pkg;

	localparam int TABLE_WORDS = 12;
	localparam int DIV_STEPS   = 32;
	localparam int DIV_LAT     = DIV_STEPS + 1;

	localparam logic [0:0] MODE_LOAD    = 1'b0;
	localparam logic [0:0] MODE_PROJECT = 1'b1;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	localparam logic [13:0] WIDTH_RESET  = 14'd640;
	localparam logic [13:0] HEIGHT_RESET = 14'd480;

	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	typedef struct packed {
		logic              mode;
		logic [3:0]        coef_index;
		logic signed [31:0] coef_value;
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
	} w2s_in_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic signed [31:0] depth;
		logic               zero_depth;
		logic               saturated;
	} w2s_out_t;

	// Camera-space point after the transform stages
	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic               sat;
	} w2s_cam_t;

	// Quotient leaving the divider
	typedef struct packed {
		logic signed [31:0] q;
		logic               sat;
	} w2s_quo_t;

	// Fields that ride alongside the divider
	typedef struct packed {
		logic               valid;
		logic signed [31:0] depth;
		logic               zero;
		logic               sat;
	} w2s_side_t;

endpackage

### hdl/w2s_xform.sv
// Coefficient table and two-stage rotate-and-translate datapath.
module w2s_xform (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             take,
	input  w2s_pkg::w2s_in_t in_data,
	output logic             valid_s2,
	output w2s_pkg::w2s_cam_t cam_s2
);
	import w2s_pkg::*;

	logic signed [31:0] coef_q [TABLE_WORDS];
	logic signed [31:0] world [3];
	logic signed [63:0] prod_s1 [9];
	logic signed [31:0] trans_s1 [3];
	logic               valid_s1;
	logic signed [31:0] cam_c [3];
	logic               cam_sat [3];

	assign world[0] = in_data.world_x;
	assign world[1] = in_data.world_y;
	assign world[2] = in_data.world_z;

	// Load one coefficient per mode-0 transfer; drop slots past the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_WORDS; i++) coef_q[i] <= '0;
		end else if (take && in_data.mode == MODE_LOAD &&
				in_data.coef_index < 4'(TABLE_WORDS)) begin
			coef_q[in_data.coef_index] <= in_data.coef_value;
		end
	end

	// Stage 1: nine products and the translation row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= take && in_data.mode == MODE_PROJECT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r*3+c] <= world[r] * coef_q[r*3+c];
				end
			end
			for (int c = 0; c < 3; c++) trans_s1[c] <= coef_q[9+c];
		end
	end

	// Stage 2 logic: exact sum, floor to Q16.16, translate, saturate
	always_comb begin
		logic signed [65:0] sum;
		logic signed [50:0] tot;
		for (int c = 0; c < 3; c++) begin
			sum = 66'(prod_s1[c]) + 66'(prod_s1[3+c]) + 66'(prod_s1[6+c]);
			tot = 51'($signed(sum[65:16])) + 51'(trans_s1[c]);
			if (tot > 51'(S32_MAX)) begin
				cam_c[c]   = S32_MAX;
				cam_sat[c] = 1'b1;
			end else if (tot < 51'(S32_MIN)) begin
				cam_c[c]   = S32_MIN;
				cam_sat[c] = 1'b1;
			end else begin
				cam_c[c]   = tot[31:0];
				cam_sat[c] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cam_s2.cx  <= cam_c[0];
			cam_s2.cy  <= cam_c[1];
			cam_s2.cz  <= cam_c[2];
			cam_s2.sat <= cam_sat[0] | cam_sat[1] | cam_sat[2];
		end
	end

endmodule

### hdl/w2s_div.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation.
module w2s_div (
	input  logic               clk,
	input  logic               en,
	input  logic signed [62:0] num,
	input  logic signed [31:0] den,
	output w2s_pkg::w2s_quo_t  quo
);
	import w2s_pkg::*;

	logic [31:0] rem_s  [DIV_STEPS+1];
	logic [31:0] nlo_s  [DIV_STEPS+1];
	logic [31:0] quo_s  [DIV_STEPS+1];
	logic [31:0] den_s  [DIV_STEPS+1];
	logic        neg_s  [DIV_STEPS+1];
	logic        ovf_s  [DIV_STEPS+1];

	logic [62:0] num_mag;
	logic [31:0] den_mag;

	assign num_mag = num[62] ? 63'(-num) : 63'(num);
	assign den_mag = den[31] ? 32'(-den) : 32'(den);

	// Entry stage: magnitudes, sign, overflow of the upper half
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {2'b00, num_mag[61:32]};
			nlo_s[0] <= num_mag[31:0];
			quo_s[0] <= '0;
			den_s[0] <= den_mag;
			neg_s[0] <= num[62] ^ den[31];
			ovf_s[0] <= {2'b00, num_mag[61:32]} >= den_mag;
		end
	end

	// One trial subtract per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [32:0] trial;
		logic        ge;
		assign trial = {rem_s[k], nlo_s[k][DIV_STEPS-1-k]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? 32'(trial - {1'b0, den_s[k]}) : trial[31:0];
				nlo_s[k+1] <= nlo_s[k];
				quo_s[k+1] <= {quo_s[k][30:0], ge};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// Apply sign and clip to the 32-bit range
	always_comb begin
		logic [31:0] mag;
		mag = quo_s[DIV_STEPS];
		if (ovf_s[DIV_STEPS]) begin
			quo.sat = 1'b1;
			quo.q   = neg_s[DIV_STEPS] ? S32_MIN : S32_MAX;
		end else if (neg_s[DIV_STEPS]) begin
			quo.sat = mag > 32'h80000000;
			quo.q   = quo.sat ? S32_MIN : 32'(-mag);
		end else begin
			quo.sat = mag[31];
			quo.q   = mag[31] ? S32_MAX : mag;
		end
	end

endmodule

### hdl/world_to_screen_projection_unit.sv
// Top level of the world-to-screen projection unit.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall   | in_data  (w2s_in_t)
//  out     | output    | out_valid / out_stall | out_data (w2s_out_t)
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// One item enters per cycle while the output is not stalled; a projection result
// passes 37 register stages (two transform stages, one scaling multiply, 33 divider
// stages, output register; the first is loaded at the transfer) before it is offered.
// Most of that depth is the 32 one-bit stages that each of the two dividers holds.
// Load items update the coefficient table at their transfer and give no result.
// Reset clears the table, restores the screen scales and empties the pipeline.
// A stalled output freezes the whole pipeline; no item is lost or repeated.
module world_to_screen_projection_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  w2s_pkg::w2s_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output w2s_pkg::w2s_out_t out_data,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [13:0]       cfg_data
);
	import w2s_pkg::*;

	logic               en;
	logic               take;
	logic [13:0]        width_q;
	logic [13:0]        height_q;
	logic               valid_s2;
	w2s_cam_t           cam_s2;
	logic               valid_s3;
	logic signed [62:0] nx_s3;
	logic signed [62:0] ny_s3;
	w2s_side_t          side_s3;
	w2s_side_t          side_d [DIV_LAT];
	w2s_quo_t           qx;
	w2s_quo_t           qy;
	logic signed [46:0] px;
	logic signed [46:0] py;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign take     = in_valid && en;

	// Hold the screen scales
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	w2s_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.take     (take),
		.in_data  (in_data),
		.valid_s2 (valid_s2),
		.cam_s2   (cam_s2)
	);

	// Stage 3: scale camera x and y into the numerators
	assign px = cam_s2.cx * $signed({1'b0, width_q});
	assign py = cam_s2.cy * $signed({1'b0, height_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s3         <= {px, 16'h0000};
			ny_s3         <= {py, 16'h0000};
			side_s3.valid <= valid_s2;
			side_s3.depth <= cam_s2.cz;
			side_s3.zero  <= cam_s2.cz == '0;
			side_s3.sat   <= cam_s2.sat;
		end
	end

	w2s_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (nx_s3),
		.den (side_s3.depth),
		.quo (qx)
	);

	w2s_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (ny_s3),
		.den (side_s3.depth),
		.quo (qy)
	);

	// Carry depth and flags alongside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) side_d[i] <= '0;
		end else if (en) begin
			side_d[0].valid <= valid_s3 && side_s3.valid;
			side_d[0].depth <= side_s3.depth;
			side_d[0].zero  <= side_s3.zero;
			side_d[0].sat   <= side_s3.sat;
			for (int i = 1; i < DIV_LAT; i++) side_d[i] <= side_d[i-1];
		end
	end

	// Output register: force zero on zero depth, merge flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= side_d[DIV_LAT-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.screen_x   <= side_d[DIV_LAT-1].zero ? '0 : qx.q;
			out_data.screen_y   <= side_d[DIV_LAT-1].zero ? '0 : qy.q;
			out_data.depth      <= side_d[DIV_LAT-1].depth;
			out_data.zero_depth <= side_d[DIV_LAT-1].zero;
			out_data.saturated  <= side_d[DIV_LAT-1].sat |
				(!side_d[DIV_LAT-1].zero & (qx.sat | qy.sat));
		end
	end

	a_zero_xy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zero_depth |->
			out_data.screen_x == '0 && out_data.screen_y == '0)
		else $error("zero depth result with nonzero screen position");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.depth == '0) == out_data.zero_depth)
		else $error("zero_depth flag disagrees with depth");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

### test/tb_world_to_screen_projection_unit.sv
// Testbench for the world-to-screen projection unit: directed and random items against a predictor.
`timescale 1ns / 100ps

module tb_world_to_screen_projection_unit;
	import w2s_pkg::*;

	localparam int SETTLE_CYCLES = 60;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	w2s_in_t  in_data;
	logic     out_valid;
	logic     out_stall;
	w2s_out_t out_data;
	logic     cfg_we;
	logic [0:0]  cfg_index;
	logic [13:0] cfg_data;

	// predictor state
	logic signed [31:0] coef_tbl [TABLE_WORDS];
	logic [13:0] scale_w;
	logic [13:0] scale_h;
	w2s_out_t    expected_q [$];

	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold_cycles;
	int err_count;

	world_to_screen_projection_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// clip to signed 32 bits and note the clipping
	function automatic logic signed [31:0] clip32(input logic signed [65:0] v, inout bit f);
		if (v > 66'sd2147483647) begin
			f = 1'b1;
			return S32_MAX;
		end
		if (v < -66'sd2147483648) begin
			f = 1'b1;
			return S32_MIN;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] camera_axis(input int col,
			input logic signed [31:0] wx, input logic signed [31:0] wy,
			input logic signed [31:0] wz, inout bit f);
		logic signed [65:0] a, b, c, acc;
		a = wx;
		b = wy;
		c = wz;
		acc = a * 66'(coef_tbl[col]) + b * 66'(coef_tbl[3 + col]) + c * 66'(coef_tbl[6 + col]);
		acc = (acc >>> 16) + 66'(coef_tbl[9 + col]);
		return clip32(acc, f);
	endfunction

	function automatic w2s_out_t project_point(input w2s_in_t it);
		w2s_out_t r;
		bit f;
		logic signed [31:0] cx, cy, cz;
		longint nx, ny;
		f = 1'b0;
		cx = camera_axis(0, it.world_x, it.world_y, it.world_z, f);
		cy = camera_axis(1, it.world_x, it.world_y, it.world_z, f);
		cz = camera_axis(2, it.world_x, it.world_y, it.world_z, f);
		r = '0;
		r.depth = cz;
		if (cz == 0) begin
			r.zero_depth = 1'b1;
		end else begin
			nx = longint'(cx) * longint'({50'd0, scale_w}) * 64'sd65536;
			ny = longint'(cy) * longint'({50'd0, scale_h}) * 64'sd65536;
			r.screen_x = clip32(66'(nx / longint'(cz)), f);
			r.screen_y = clip32(66'(ny / longint'(cz)), f);
		end
		r.saturated = f;
		return r;
	endfunction

	// drive one item, wait for its transfer, then update the predictor
	task automatic send_item(input w2s_in_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (it.mode == MODE_LOAD) begin
			if (it.coef_index < TABLE_WORDS)
				coef_tbl[it.coef_index] = it.coef_value;
		end else begin
			expected_q.push_back(project_point(it));
		end
	endtask

	task automatic load_coef(input int idx, input logic signed [31:0] v);
		w2s_in_t it;
		it = '0;
		it.mode = MODE_LOAD;
		it.coef_index = idx[3:0];
		it.coef_value = v;
		it.world_x = $urandom;
		send_item(it);
	endtask

	task automatic project(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z);
		w2s_in_t it;
		it = '0;
		it.mode = MODE_PROJECT;
		it.coef_index = $urandom;
		it.coef_value = $urandom;
		it.world_x = x;
		it.world_y = y;
		it.world_z = z;
		send_item(it);
	endtask

	// stop offering, let every result arrive and the pipeline empty out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [13:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDTH)
			scale_w = v;
		else
			scale_h = v;
	endtask

	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $signed($urandom_range(65535)) - 32'sd32768;
			2: return $signed(32'($urandom_range(2097151))) - 32'sd1048576;
			3: return $urandom_range(1) ? S32_MAX : S32_MIN;
			default: return $signed(32'($urandom_range(33554431))) - 32'sd16777216;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_coef();
		case ($urandom_range(4))
			0: return $urandom;
			1: return 32'sd0;
			2: return $signed(32'($urandom_range(262143))) - 32'sd131072;
			default: return $signed(32'($urandom_range(131071))) - 32'sd65536;
		endcase
	endfunction

	// compare each transfer on the result side with the oldest expectation
	always @(posedge clk) begin
		w2s_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				err_count++;
				$display("%0t: result with none expected: %h", $realtime, out_data);
			end else begin
				e = expected_q.pop_front();
				if (out_data.screen_x !== e.screen_x) begin
					err_count++;
					$display("%0t: screen_x exp %h got %h", $realtime, e.screen_x, out_data.screen_x);
				end
				if (out_data.screen_y !== e.screen_y) begin
					err_count++;
					$display("%0t: screen_y exp %h got %h", $realtime, e.screen_y, out_data.screen_y);
				end
				if (out_data.depth !== e.depth) begin
					err_count++;
					$display("%0t: depth exp %h got %h", $realtime, e.depth, out_data.depth);
				end
				if (out_data.zero_depth !== e.zero_depth) begin
					err_count++;
					$display("%0t: zero_depth exp %b got %b", $realtime, e.zero_depth,
						out_data.zero_depth);
				end
				if (out_data.saturated !== e.saturated) begin
					err_count++;
					$display("%0t: saturated exp %b got %b", $realtime, e.saturated,
						out_data.saturated);
				end
			end
		end
	end

	// stall the result side at random, or hold it off for a counted stretch
	always @(posedge clk) begin
		if (rx_hold_cycles > 0) begin
			rx_hold_cycles <= rx_hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	task automatic test_reset_state();
		// empty table gives zero depth everywhere
		project(32'sd65536, -32'sd65536, S32_MAX);
		project(S32_MIN, S32_MIN, S32_MIN);
		// out-of-range slots are dropped
		for (int i = 12; i < 16; i++)
			load_coef(i, 32'sh12345678);
		project(32'sd100, 32'sd200, 32'sd300);
		drain();
	endtask

	task automatic test_directed_points();
		// identity rotation, camera pushed back in z
		for (int i = 0; i < TABLE_WORDS; i++)
			load_coef(i, (i == 0 || i == 4 || i == 8) ? 32'sd65536 : 32'sd0);
		load_coef(11, 32'sd327680);
		project(32'sd65536, 32'sd131072, 32'sd0);
		project(-32'sd65536, -32'sd98304, 32'sd65536);
		project(32'sd0, 32'sd0, -32'sd327680);
		project(S32_MAX, S32_MIN, 32'sd0);
		project(S32_MAX, S32_MAX, S32_MAX);
		project(32'sd7, -32'sd3, 32'sd1);
		// negative sub-unit products check flooring
		load_coef(0, -32'sd1);
		load_coef(4, 32'sd3);
		project(32'sd5, -32'sd5, -32'sd327679);
		// translation saturation
		load_coef(9, S32_MAX);
		load_coef(11, S32_MIN);
		project(S32_MAX, 32'sd0, S32_MIN);
		project(32'sd0, 32'sd0, 32'sd0);
		drain();
	endtask

	task automatic test_scale_extremes();
		logic [13:0] settings [5] = '{14'd0, 14'd1, 14'd8192, 14'd16383, 14'd640};
		for (int i = 0; i < TABLE_WORDS; i++)
			load_coef(i, (i == 0 || i == 4 || i == 8) ? 32'sd65536 : 32'sd0);
		for (int s = 0; s < 5; s++) begin
			write_reg(REG_WIDTH, settings[s]);
			write_reg(REG_HEIGHT, settings[4 - s]);
			project(32'sd65536, -32'sd65536, 32'sd65536);
			project(S32_MAX, S32_MIN, 32'sd1);
			project(32'sd12345, -32'sd54321, 32'sd70000);
		end
		write_reg(REG_HEIGHT, 14'd480);
	endtask

	task automatic test_random(input int n_items);
		w2s_in_t it;
		for (int k = 0; k < n_items; k++) begin
			it.mode = ($urandom_range(99) < 75) ? MODE_PROJECT : MODE_LOAD;
			it.coef_index = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(11));
			it.coef_value = rand_coef();
			it.world_x = rand_q();
			it.world_y = rand_q();
			it.world_z = rand_q();
			send_item(it);
		end
		drain();
	endtask

	task automatic test_backpressure();
		// receiver holds off while the sender keeps offering
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_cycles = 300;
		for (int k = 0; k < 120; k++)
			project(rand_q(), rand_q(), rand_q());
		// sender pauses until every result is back, then resumes
		drain();
		for (int k = 0; k < 30; k++)
			project(rand_q(), rand_q(), rand_q());
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data  = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_cycles = 0;
		err_count = 0;
		for (int i = 0; i < TABLE_WORDS; i++)
			coef_tbl[i] = '0;
		scale_w = WIDTH_RESET;
		scale_h = HEIGHT_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 6;
		rx_idle_pct = 75;
		test_reset_state();
		test_directed_points();
		test_scale_extremes();
		test_random(650);
		write_reg(REG_WIDTH, 14'd1920);
		write_reg(REG_HEIGHT, 14'd1080);
		tx_idle_pct = 75;
		rx_idle_pct = 6;
		test_random(650);
		write_reg(REG_WIDTH, 14'd8192);
		write_reg(REG_HEIGHT, 14'd1);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random(450);
		test_backpressure();

		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

endmodule
